>>> hw/rtl/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg: shared types and constants for the double hash table
// Table geometry, hash constants, status codes and result structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dht_pkg;

  localparam int TABLE_SLOTS     = 1024;  // power of two
  localparam int SLOTS_PER_BLOCK = 64;    // power of two
  localparam int SLOT_W          = $clog2(TABLE_SLOTS);
  localparam int OFF_W           = $clog2(SLOTS_PER_BLOCK);
  localparam int KEY_W           = 32;
  localparam int ADDR_W          = 32;

  localparam logic [KEY_W-1:0] MUL_ROUND1 = 32'h7feb352d;
  localparam logic [KEY_W-1:0] MUL_ROUND2 = 32'h846ca68b;
  localparam logic [KEY_W-1:0] MUL_STEP   = 32'h9e3779b1;
  localparam int SHIFT_A = 16;
  localparam int SHIFT_B = 15;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [KEY_W-1:0]  key_t;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_CLAIMED = 2'd1,
    ST_MISS    = 2'd2
  } status_t;

  typedef struct packed {
    slot_t home;
    slot_t step;
  } hash_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/dht_ifs.sv
// ----------------------------------------------------------------------------
// dht channel interfaces
// Valid/ready channels for config writes, requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface dht_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dht_pkg::ADDR_W-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dht_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [dht_pkg::KEY_W-1:0]     key;
  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface dht_resp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [dht_pkg::SLOT_W-1:0]    slot_index;
  logic [dht_pkg::ADDR_W-1:0]    block_address;
  logic [dht_pkg::OFF_W-1:0]     block_offset;
  modport source (output valid, output status, output slot_index, output block_address,
                  output block_offset, input ready);
  modport sink   (input valid, input status, input slot_index, input block_address,
                  input block_offset, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/double_hash_table_lookup_insert.sv
// Flow: P = slots probed (1..TABLE_SLOTS); the hash unit computes home and step, then
//   each probe is a RAM read plus a compare, then the response register loads.
// Requests: taken one at a time;
//   the next request is taken the cycle after the response register loads.
// Reset: synchronous, active high; a clearing pass of all TABLE_SLOTS (1024) slots
//   empties the slot RAM and holds off requests. Config beats are always taken.
// ----------------------------------------------------------------------------
// double_hash_table_lookup_insert
// Open-addressed key table with double-hash probing, lookup or lookup-and-claim.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_table_lookup_insert (
  input  wire logic  clk,
  input  wire logic  rst,
  dht_cfg_if.sink    cfg,
  dht_req_if.sink    req,
  dht_resp_if.source resp
);

  // Sequencer states
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,  // wiping the slot RAM after reset
    S_IDLE  = 6'b000010,  // waiting for a request beat
    S_HASH  = 6'b000100,  // shared multiplier computing home/step
    S_READ  = 6'b001000,  // issuing the slot RAM read
    S_CHECK = 6'b010000,  // comparing the read word
    S_DONE  = 6'b100000   // handing result to the response register
  } state_t;

  localparam int WORD_W = dht_pkg::KEY_W + 1;  // {valid, key}

  state_t                      state;
  logic [dht_pkg::ADDR_W-1:0]  base;
  logic                        mode_q;
  dht_pkg::key_t               key_q;
  dht_pkg::slot_t              idx;
  dht_pkg::slot_t              step;
  dht_pkg::slot_t              cnt;
  dht_pkg::slot_t              clr_addr;
  dht_pkg::status_t            res_status;
  dht_pkg::slot_t              res_slot;

  // Slot RAM: bit KEY_W is the valid flag, the rest is the stored key
  logic [WORD_W-1:0]           mem [dht_pkg::TABLE_SLOTS];
  logic [WORD_W-1:0]           rd_word;
  logic                        mem_we;
  dht_pkg::slot_t              mem_addr;
  logic [WORD_W-1:0]           mem_wdata;

  logic                        hash_start;
  logic                        hash_done;
  dht_pkg::hash_res_t          hash_res;

  logic                        out_valid;
  logic                        out_free;
  logic                        slot_used;
  logic                        key_hit;
  logic                        last_probe;

  assign cfg.ready  = 1'b1;
  assign req.ready  = (state == S_IDLE);
  assign hash_start = req.valid && req.ready;

  assign slot_used  = rd_word[dht_pkg::KEY_W];
  assign key_hit    = slot_used && (rd_word[dht_pkg::KEY_W-1:0] == key_q);
  assign last_probe = (cnt == dht_pkg::slot_t'(dht_pkg::TABLE_SLOTS - 1));
  assign out_free   = !out_valid || resp.ready;

  dht_hash_unit u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (req.key),
    .done  (hash_done),
    .res   (hash_res)
  );

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg.valid && cfg.ready) begin
      base <= cfg.data;
    end
  end

  // RAM write port: clearing pass, or a claim on an empty slot in insert mode
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx;
    mem_wdata = {1'b1, key_q};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr;
      mem_wdata = '0;
    end else if (state == S_CHECK && !slot_used && mode_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) rd_word <= mem[idx];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + dht_pkg::slot_t'(1);
          if (clr_addr == dht_pkg::slot_t'(dht_pkg::TABLE_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (hash_start) state <= S_HASH;
        end
        S_HASH: begin
          if (hash_done) state <= S_READ;
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if ((!slot_used && mode_q) || key_hit || last_probe) begin
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        default: begin  // S_DONE
          if (out_free) state <= S_IDLE;
        end
      endcase
    end
  end

  // Probe datapath
  always_ff @(posedge clk) begin
    if (hash_start) begin
      mode_q <= req.mode;
      key_q  <= req.key;
    end
    if (state == S_HASH && hash_done) begin
      idx  <= hash_res.home;
      step <= hash_res.step;
      cnt  <= '0;
    end
    if (state == S_CHECK) begin
      if (!slot_used && mode_q) begin
        res_status <= dht_pkg::ST_CLAIMED;
        res_slot   <= idx;
      end else if (key_hit) begin
        res_status <= dht_pkg::ST_FOUND;
        res_slot   <= idx;
      end else if (last_probe) begin
        res_status <= dht_pkg::ST_MISS;
        res_slot   <= '0;
      end else begin
        idx <= idx + step;  // wraps modulo table size
        cnt <= cnt + dht_pkg::slot_t'(1);
      end
    end
  end

  // Response register; a finished item waits in S_DONE while it is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (resp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      resp.status     <= res_status;
      resp.slot_index <= res_slot;
      if (res_status == dht_pkg::ST_MISS) begin
        resp.block_address <= '0;
        resp.block_offset  <= '0;
      end else begin
        resp.block_address <= base + dht_pkg::ADDR_W'(res_slot >> dht_pkg::OFF_W);
        resp.block_offset  <= res_slot[dht_pkg::OFF_W-1:0];
      end
    end
  end

  assign resp.valid = out_valid;

endmodule

`default_nettype wire

>>> hw/rtl/dht_hash_unit.sv
// ----------------------------------------------------------------------------
// dht_hash_unit: home slot and probe step from one shared multiplier
// Three multiplies, in H_IDLE, H_R1 and H_R2, product registered between rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_hash_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire dht_pkg::key_t      key,
  output logic                    done,
  output dht_pkg::hash_res_t      res
);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_R1   = 4'b0010,
    H_R2   = 4'b0100,
    H_R3   = 4'b1000
  } hstate_t;

  hstate_t       state;
  dht_pkg::key_t key_q;
  dht_pkg::key_t prod;
  dht_pkg::key_t mul_a;
  dht_pkg::key_t mul_b;
  dht_pkg::key_t product;

  always_comb begin
    unique case (state)
      H_IDLE: begin
        mul_a = key ^ (key >> dht_pkg::SHIFT_A);
        mul_b = dht_pkg::MUL_ROUND1;
      end
      H_R1: begin
        mul_a = prod ^ (prod >> dht_pkg::SHIFT_B);
        mul_b = dht_pkg::MUL_ROUND2;
      end
      H_R2: begin
        mul_a = key_q;
        mul_b = dht_pkg::MUL_STEP;
      end
      default: begin
        mul_a = prod;
        mul_b = '0;
      end
    endcase
    product = mul_a * mul_b;  // low word only
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == H_R3);
      unique case (state)
        H_IDLE:  if (start) state <= H_R1;
        H_R1:    state <= H_R2;
        H_R2:    state <= H_R3;
        default: state <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == H_IDLE && start) key_q <= key;
    if ((state == H_IDLE && start) || state == H_R1 || state == H_R2) prod <= product;
    if (state == H_R2) res.home <= dht_pkg::slot_t'(prod ^ (prod >> dht_pkg::SHIFT_A));
    if (state == H_R3) res.step <= dht_pkg::slot_t'(prod) | dht_pkg::slot_t'(1);
  end

endmodule

`default_nettype wire

>>> hw/rtl/dht_checker.sv
// ----------------------------------------------------------------------------
// dht_checker: port-level assertions for the double hash table
// Bound to the top level; watches the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        resp_valid,
  input wire logic                        resp_ready,
  input wire logic [1:0]                  status,
  input wire logic [dht_pkg::SLOT_W-1:0]  slot_index,
  input wire logic [dht_pkg::ADDR_W-1:0]  block_address,
  input wire logic [dht_pkg::OFF_W-1:0]   block_offset
);

  // Held response beat stays put
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(status) && $stable(slot_index)
      && $stable(block_address) && $stable(block_offset))
    else $error("response changed while stalled");

  // A miss carries zero location fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && status == dht_pkg::ST_MISS |->
      slot_index == '0 && block_address == '0 && block_offset == '0)
    else $error("miss with nonzero location");

  // Offset is the low part of the slot index
  a_offset: assert property (@(posedge clk) disable iff (rst)
    resp_valid && status != dht_pkg::ST_MISS |->
      block_offset == slot_index[dht_pkg::OFF_W-1:0])
    else $error("block offset does not match slot index");

  // One request in flight: busy right after a request beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // Reset empties the response side and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    rst |=> !resp_valid && !req_ready)
    else $error("not quiet after reset");

endmodule

bind double_hash_table_lookup_insert dht_checker u_dht_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .resp_valid    (resp.valid),
  .resp_ready    (resp.ready),
  .status        (resp.status),
  .slot_index    (resp.slot_index),
  .block_address (resp.block_address),
  .block_offset  (resp.block_offset)
);

`default_nettype wire
